>>> rtl/core/pcdb_pkg.sv
// ----------------------------------------------------------------------------
// pcdb_pkg
// Shared widths, codes and control types for the par-curve discount
// factor bootstrap core.
// ----------------------------------------------------------------------------
package pcdb_pkg;

    // field widths
    localparam int YLD_W      = 23;   // par yield, unsigned Q7.16
    localparam int DF_W       = 32;   // discount factor, signed Q2.30
    localparam int TIDX_W     = 6;    // tenor index
    localparam int ST_W       = 2;    // status code
    localparam int PPY_W      = 4;    // periods per year
    localparam int FACE_W     = 16;   // face value
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int SUM_W    = 39;                 // running sum, signed Q.30
    localparam int MS_W     = 39;                 // magnitude of running sum
    localparam int MS_LO_W  = 20;                 // low partial product slice
    localparam int MS_HI_W  = MS_W - MS_LO_W;
    localparam int K_W      = FACE_W + PPY_W;     // face * periods
    localparam int DEN_W    = K_W + 17;           // (k << 16) + yield
    localparam int PROD_W   = YLD_W + MS_W;       // yield * |sum|
    localparam int NUM_W    = K_W + 47;           // numerator magnitude
    localparam int Q_W      = 33;                 // quotient bits developed
    localparam int QR_W     = Q_W + 1;            // rounded quotient

    // parameter defaults
    localparam int MAX_TENORS_DEF = 64;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PPY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FACE = 1'b1;

    // register reset values
    localparam logic [PPY_W-1:0]  PPY_RST  = 4'd2;
    localparam logic [FACE_W-1:0] FACE_RST = 16'd100;

    // controller states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MLO  = 8'b0000_0010,
        S_MHI  = 8'b0000_0100,
        S_NUM  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_RND  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic mul_lo;
        logic mul_hi;
        logic num;
        logic div_init;
        logic div_step;
        logic rnd;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } t_sts;

endpackage

>>> rtl/core/pcdb_ctrl.sv
// ----------------------------------------------------------------------------
// pcdb_ctrl
// Sequencer for one request: multiply, form numerator, divide, round,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module pcdb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  pcdb_pkg::t_sts  i_sts,
    output pcdb_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    pcdb_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcdb_pkg::S_IDLE: if (i_in_valid) n_state = pcdb_pkg::S_MLO;
            pcdb_pkg::S_MLO:  n_state = pcdb_pkg::S_MHI;
            pcdb_pkg::S_MHI:  n_state = pcdb_pkg::S_NUM;
            pcdb_pkg::S_NUM:  n_state = pcdb_pkg::S_CHK;
            pcdb_pkg::S_CHK:  n_state = pcdb_pkg::S_DIV;
            pcdb_pkg::S_DIV:  if (i_sts.div_last) n_state = pcdb_pkg::S_RND;
            pcdb_pkg::S_RND:  if (out_free) n_state = pcdb_pkg::S_FIN;
            pcdb_pkg::S_FIN:  n_state = pcdb_pkg::S_IDLE;
            default:          n_state = pcdb_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == pcdb_pkg::S_IDLE) && i_in_valid;
        o_cmd.mul_lo   = (r_state == pcdb_pkg::S_MLO);
        o_cmd.mul_hi   = (r_state == pcdb_pkg::S_MHI);
        o_cmd.num      = (r_state == pcdb_pkg::S_NUM);
        o_cmd.div_init = (r_state == pcdb_pkg::S_CHK);
        o_cmd.div_step = (r_state == pcdb_pkg::S_DIV);
        o_cmd.rnd      = (r_state == pcdb_pkg::S_RND);
        o_cmd.fin      = (r_state == pcdb_pkg::S_FIN);
    end

    // output valid: set on finish, cleared when the result is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (r_state == pcdb_pkg::S_FIN)   n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcdb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != pcdb_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/pcdb_dpath.sv
// ----------------------------------------------------------------------------
// pcdb_dpath
// Configuration registers, running sum and tenor count, split multiplier,
// numerator former, restoring divider, rounding and result register.
// ----------------------------------------------------------------------------
module pcdb_dpath #(
    parameter int MAX_TENORS = pcdb_pkg::MAX_TENORS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [pcdb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcdb_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [pcdb_pkg::YLD_W-1:0]             i_par_yield,
    input  logic                                   i_restart,
    input  pcdb_pkg::t_cmd                         i_cmd,
    output pcdb_pkg::t_sts                         o_sts,
    output logic signed [pcdb_pkg::DF_W-1:0]       o_disc_fac,
    output logic [pcdb_pkg::TIDX_W-1:0]            o_tenor_index,
    output logic [pcdb_pkg::ST_W-1:0]              o_status
);

    localparam int CNT_W  = $clog2(MAX_TENORS + 1);
    localparam int STEP_W = $clog2(pcdb_pkg::Q_W);
    localparam int YW     = pcdb_pkg::YLD_W;
    localparam int SW     = pcdb_pkg::SUM_W;
    localparam int MW     = pcdb_pkg::MS_W;
    localparam int MLW    = pcdb_pkg::MS_LO_W;
    localparam int MHW    = pcdb_pkg::MS_HI_W;
    localparam int KW     = pcdb_pkg::K_W;
    localparam int DW     = pcdb_pkg::DEN_W;
    localparam int PW     = pcdb_pkg::PROD_W;
    localparam int NW     = pcdb_pkg::NUM_W;
    localparam int QW     = pcdb_pkg::Q_W;
    localparam int QRW    = pcdb_pkg::QR_W;
    localparam int FW     = pcdb_pkg::DF_W;
    localparam int TW     = pcdb_pkg::TIDX_W;
    localparam int PPW    = pcdb_pkg::PPY_W;
    localparam int FCW    = pcdb_pkg::FACE_W;

    // configuration
    logic [PPW-1:0]          r_ppy;
    logic [FCW-1:0]          r_face;

    // state
    logic signed [SW-1:0]    r_sum;
    logic [CNT_W-1:0]        r_count;

    // per-request working registers
    logic [YW-1:0]           r_y;
    logic [KW-1:0]           r_k;
    logic [DW-1:0]           r_den;
    logic [MW-1:0]           r_ms;
    logic                    r_sneg;
    logic                    r_full;
    logic [PW-1:0]           r_prod;
    logic [NW-1:0]           r_num;
    logic                    r_aneg;
    logic                    r_big;
    logic [DW-1:0]           r_rem;
    logic [QW-1:0]           r_nlo;
    logic [QW-1:0]           r_q;
    logic [STEP_W-1:0]       r_step;
    logic [QRW-1:0]          r_qr;

    // result register
    logic signed [FW-1:0]    r_out_d;
    logic [TW-1:0]           r_out_idx;
    logic [pcdb_pkg::ST_W-1:0] r_out_st;

    // start-of-request terms
    logic signed [SW-1:0]    eff_sum;
    logic [CNT_W-1:0]        eff_cnt;
    logic [PPW-1:0]          ppy_eff;
    logic [KW-1:0]           k_val;
    logic [DW-1:0]           den_val;
    logic [MW-1:0]           ms_val;

    assign eff_sum = i_restart ? '0 : r_sum;
    assign eff_cnt = i_restart ? '0 : r_count;
    assign ppy_eff = (r_ppy == '0) ? PPW'(1) : r_ppy;
    assign k_val   = KW'(r_face) * KW'(ppy_eff);
    assign den_val = DW'({k_val, 16'd0}) + DW'(i_par_yield);
    assign ms_val  = eff_sum[SW-1] ? MW'(-eff_sum) : MW'(eff_sum);

    // partial products of yield * |sum|
    logic [YW+MLW-1:0]       pp_lo;
    logic [YW+MHW-1:0]       pp_hi;

    assign pp_lo = r_y * r_ms[MLW-1:0];
    assign pp_hi = r_y * r_ms[MW-1:MLW];

    // numerator: k*2^46 +/- yield*|sum|
    logic [NW-1:0]           a_ext;
    logic [NW-1:0]           p_ext;
    logic [NW-1:0]           n_add;
    logic [NW-1:0]           n_pos;
    logic [NW-1:0]           n_neg;
    logic                    a_lt_p;

    assign a_ext  = NW'({r_k, 46'd0});
    assign p_ext  = NW'(r_prod);
    assign n_add  = a_ext + p_ext;
    assign n_pos  = a_ext - p_ext;
    assign n_neg  = p_ext - a_ext;
    assign a_lt_p = (a_ext < p_ext);

    // divider step
    logic [DW:0]             trial;
    logic                    ge;
    logic                    round_up;

    assign trial    = {r_rem, r_nlo[QW-1]};
    assign ge       = (trial >= {1'b0, r_den});
    assign round_up = ({r_rem, 1'b0} >= {1'b0, r_den});

    assign o_sts.div_last = (r_step == STEP_W'(QW - 1));

    // final value and status
    logic signed [FW-1:0]       fin_d;
    logic [pcdb_pkg::ST_W-1:0]  fin_st;

    always_comb begin
        fin_d  = '0;
        fin_st = pcdb_pkg::ST_OK;
        if (r_full) begin
            fin_st = pcdb_pkg::ST_FULL;
        end else if (r_den == '0) begin
            fin_st = pcdb_pkg::ST_SAT;
        end else if (!r_aneg) begin
            if (r_big || (r_qr > QRW'(32'h7FFF_FFFF))) begin
                fin_d  = 32'sh7FFF_FFFF;
                fin_st = pcdb_pkg::ST_SAT;
            end else begin
                fin_d = r_qr[FW-1:0];
            end
        end else begin
            if (r_big || (r_qr > QRW'(32'h8000_0000))) begin
                fin_d  = 32'sh8000_0000;
                fin_st = pcdb_pkg::ST_SAT;
            end else begin
                fin_d = -r_qr[FW-1:0];
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppy  <= pcdb_pkg::PPY_RST;
            r_face <= pcdb_pkg::FACE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pcdb_pkg::REG_PPY:  r_ppy  <= i_cfg_data[PPW-1:0];
                pcdb_pkg::REG_FACE: r_face <= i_cfg_data[FCW-1:0];
                default: ;
            endcase
        end
    end

    // running sum and tenor count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.start) begin
            r_sum   <= eff_sum;
            r_count <= eff_cnt;
        end else if (i_cmd.fin && !r_full) begin
            r_sum   <= r_sum + SW'(fin_d);
            r_count <= r_count + CNT_W'(1);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_y    <= i_par_yield;
            r_k    <= k_val;
            r_den  <= den_val;
            r_ms   <= ms_val;
            r_sneg <= eff_sum[SW-1];
            r_full <= (eff_cnt >= CNT_W'(MAX_TENORS));
        end
        if (i_cmd.mul_lo) r_prod <= PW'(pp_lo);
        if (i_cmd.mul_hi) r_prod <= r_prod + {pp_hi, {MLW{1'b0}}};
        if (i_cmd.num) begin
            if (r_sneg) begin
                r_num  <= n_add;
                r_aneg <= 1'b0;
            end else if (a_lt_p) begin
                r_num  <= n_neg;
                r_aneg <= 1'b1;
            end else begin
                r_num  <= n_pos;
                r_aneg <= 1'b0;
            end
        end
        // upper bits checked against the divisor: at or above means |q| >= 2^33
        if (i_cmd.div_init) begin
            r_big  <= (DW'(r_num[NW-1:QW]) >= r_den);
            r_rem  <= DW'(r_num[NW-1:QW]);
            r_nlo  <= r_num[QW-1:0];
            r_q    <= '0;
            r_step <= '0;
        end
        // one quotient bit per cycle
        if (i_cmd.div_step) begin
            r_rem  <= ge ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_q    <= {r_q[QW-2:0], ge};
            r_nlo  <= {r_nlo[QW-2:0], 1'b0};
            r_step <= r_step + STEP_W'(1);
        end
        // round half away from zero on the magnitude
        if (i_cmd.rnd) r_qr <= {1'b0, r_q} + QRW'(round_up);
        if (i_cmd.fin) begin
            r_out_d   <= fin_d;
            r_out_idx <= r_full ? '0 : TW'(r_count);
            r_out_st  <= fin_st;
        end
    end

    assign o_disc_fac    = r_out_d;
    assign o_tenor_index = r_out_idx;
    assign o_status      = r_out_st;

endmodule

>>> rtl/core/par_curve_discount_bootstrap_core.sv
// ----------------------------------------------------------------------------
// par_curve_discount_bootstrap_core
// Bootstraps discount factors d = (face - c*S)/(face + c) from par yields,
// one tenor per request, keeping the running sum S of earlier factors.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   i_par_yield, i_restart
//   out       output     o_out_valid / i_out_stall o_disc_fac,
//                                                  o_tenor_index, o_status
//   cfg       input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// Requests do not overlap: the next is accepted only after the last has
// finished; the restoring divider (one quotient bit per cycle) sets most of it.
// The result register holds a finished result while the next request is
// accepted; a result waits before the register only if it is still full.
// Reset (synchronous, active low) clears the sum, the count and control
// state and loads periods_per_year = 2, face_value = 100.
// ----------------------------------------------------------------------------
module par_curve_discount_bootstrap_core #(
    parameter int MAX_TENORS = pcdb_pkg::MAX_TENORS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [pcdb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pcdb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [pcdb_pkg::YLD_W-1:0]           i_par_yield,
    input  logic                                 i_restart,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pcdb_pkg::DF_W-1:0]     o_disc_fac,
    output logic [pcdb_pkg::TIDX_W-1:0]          o_tenor_index,
    output logic [pcdb_pkg::ST_W-1:0]            o_status
);

    pcdb_pkg::t_cmd cmd;
    pcdb_pkg::t_sts sts;

    // sequencer
    pcdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // arithmetic and state
    pcdb_dpath #(
        .MAX_TENORS (MAX_TENORS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_par_yield   (i_par_yield),
        .i_restart     (i_restart),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_disc_fac    (o_disc_fac),
        .o_tenor_index (o_tenor_index),
        .o_status      (o_status)
    );

    // an accepted request keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting a request");

    // a new result only appears while a request is in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no request in progress");

    // beyond capacity results carry a zero factor and index
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == pcdb_pkg::ST_FULL)
            |-> (o_disc_fac == '0) && (o_tenor_index == '0))
        else $error("beyond-capacity result has nonzero payload");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == pcdb_pkg::ST_OK) || (o_status == pcdb_pkg::ST_FULL)
            || (o_status == pcdb_pkg::ST_SAT))
        else $error("undefined status code");

endmodule
